[rtl/lbc_pkg.sv]
package lbc_pkg;

  localparam int LBC_ENTRIES    = 16;
  localparam int LBC_KEY_WIDTH  = 32;
  localparam int LBC_DATA_WIDTH = 64;

  // capacity register
  localparam int              LBC_CAP_W     = 5;
  localparam logic [LBC_CAP_W-1:0] LBC_CAP_RESET = 5'd16;

  typedef enum logic {
    LBC_MODE_GET = 1'b0,
    LBC_MODE_PUT = 1'b1
  } lbc_mode_t;

  // out_tuser bit positions
  localparam int LBC_OUT_HIT_BIT     = 0;
  localparam int LBC_OUT_EVICTED_BIT = 1;

endpackage

[rtl/lru_block_cache_unit.sv]
// Channel  Handshake                Payload
// in_      in_tvalid / in_tready    tuser: mode; tdata: block_number, write_data
// out_     out_tvalid / out_tready  tuser: hit, evicted; tdata: read_data, evicted_block
// cfg_     cfg_valid / cfg_ready    data: capacity (always ready)
//
// One item per cycle while out_tready is high; each result is registered after
// tag compare and recency update, which run from the input register.
// Reset empties the store and sets capacity to 16; stale keys and payloads
// are never read while their entry is invalid.
// A stalled output holds its result and the item behind it; input stalls only
// when both registers are full and out_tready is low.
module lru_block_cache_unit #(
  parameter int ENTRIES    = lbc_pkg::LBC_ENTRIES,
  parameter int KEY_WIDTH  = lbc_pkg::LBC_KEY_WIDTH,
  parameter int DATA_WIDTH = lbc_pkg::LBC_DATA_WIDTH
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // block_number, write_data (zero fill to bytes)
  input  logic [((KEY_WIDTH+DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  // mode
  input  logic                                          in_tuser,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // read_data, evicted_block (zero fill to bytes)
  output logic [((KEY_WIDTH+DATA_WIDTH+7)/8)*8-1:0]     out_tdata,
  // hit, evicted
  output logic [1:0]                                    out_tuser,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [lbc_pkg::LBC_CAP_W-1:0]                 cfg_data
);
  import lbc_pkg::*;

  localparam int TDATA_W = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8;
  localparam int PAD_W   = TDATA_W - KEY_WIDTH - DATA_WIDTH;
  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > LBC_CAP_W) ? CNT_W : LBC_CAP_W;

  // input register
  logic                  s1_valid_r;
  lbc_mode_t             s1_mode_r;
  logic [KEY_WIDTH-1:0]  s1_key_r;
  logic [DATA_WIDTH-1:0] s1_data_r;

  // cache state
  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [KEY_WIDTH-1:0]  key_r     [ENTRIES];
  logic [DATA_WIDTH-1:0] payload_r [ENTRIES];
  logic [RANK_W-1:0]     rank_r    [ENTRIES];
  logic [RANK_W-1:0]     rank_nxt  [ENTRIES];
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [LBC_CAP_W-1:0]  cap_r;

  // result register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [DATA_WIDTH-1:0] out_rdata_r;
  logic                  out_ev_r;
  logic [KEY_WIDTH-1:0]  out_evkey_r;

  logic                  advance;
  logic [ENTRIES-1:0]    hit_vec, victim_vec, free_vec, first_free, ins_vec;
  logic                  hit, is_put, put_miss, evict;
  logic [RANK_W-1:0]     hit_rank, victim_rank;
  logic [DATA_WIDTH-1:0] hit_payload;
  logic [KEY_WIDTH-1:0]  victim_key;
  logic [CNT_W-1:0]      occ_dec;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= lbc_mode_t'(in_tuser);
      s1_key_r  <= in_tdata[KEY_WIDTH-1:0];
      s1_data_r <= in_tdata[KEY_WIDTH+DATA_WIDTH-1:KEY_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= LBC_CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  // parallel tag compare; matches and ranks are unique among valid entries
  assign occ_dec     = occ_r - CNT_W'(1);
  assign victim_rank = occ_dec[RANK_W-1:0];
  assign free_vec    = ~valid_r;
  assign first_free  = free_vec & (~free_vec + ENTRIES'(1));

  always_comb begin
    hit_rank    = '0;
    hit_payload = '0;
    victim_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_r[i] && (key_r[i] == s1_key_r);
      victim_vec[i] = valid_r[i] && (rank_r[i] == victim_rank);
      hit_rank      = hit_rank    | (hit_vec[i] ? rank_r[i] : '0);
      hit_payload   = hit_payload | (hit_vec[i] ? payload_r[i] : '0);
      victim_key    = victim_key  | (victim_vec[i] ? key_r[i] : '0);
    end
  end

  assign hit      = |hit_vec;
  assign is_put   = (s1_mode_r == LBC_MODE_PUT);
  assign put_miss = is_put && !hit;
  // capacity zero acts as one; the store filling up acts as the clamp
  assign evict    = put_miss && ((occ_r == CNT_W'(ENTRIES)) ||
                    ((CMP_W'(occ_r) >= CMP_W'(cap_r)) && (occ_r != '0)));
  // reuse the victim's slot on eviction, else take the first free one
  assign ins_vec  = evict ? victim_vec : first_free;

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (hit) begin
        if (hit_vec[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end else if (put_miss) begin
        if (ins_vec[i]) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (put_miss && !evict) begin
      occ_nxt = occ_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (advance) begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (advance && put_miss && ins_vec[i]) begin
        key_r[i] <= s1_key_r;
      end
      if (advance && is_put && (ins_vec[i] && !hit || hit_vec[i])) begin
        payload_r[i] <= s1_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r   <= hit;
      out_rdata_r <= (hit && !is_put) ? hit_payload : '0;
      out_ev_r    <= evict;
      out_evkey_r <= evict ? victim_key : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  generate
    if (PAD_W > 0) begin : g_pad
      assign out_tdata = {{PAD_W{1'b0}}, out_evkey_r, out_rdata_r};
    end else begin : g_nopad
      assign out_tdata = {out_evkey_r, out_rdata_r};
    end
  endgenerate
  assign out_tuser[LBC_OUT_HIT_BIT]     = out_hit_r;
  assign out_tuser[LBC_OUT_EVICTED_BIT] = out_ev_r;

  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(hit_vec))
    else $error("key matches more than one valid entry");

  a_victim_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(victim_vec))
    else $error("recency ranks not unique");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy disagrees with valid entries");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    advance && evict |=> out_valid_r && !out_hit_r && (occ_r == $past(occ_r)))
    else $error("eviction changed occupancy or reported a hit");

endmodule
